// File: hdl/anbs_pkg.sv
// anbs_pkg: shared types and constants of the annex b nal unit splitter
// used by anbs_step, anbs_out_fifo and annexb_nal_unit_splitter; no dependencies
package anbs_pkg;

   localparam int HOLD_DEPTH  = 4;
   localparam int MAX_OUT     = 2;
   localparam int FIFO_DEPTH  = 4;
   localparam int COUNT_W     = $clog2(HOLD_DEPTH + 2);
   localparam int EMIT_W      = $clog2(MAX_OUT + 1);
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] ZeroByte = 8'h00;
   localparam logic [7:0] OneByte  = 8'h01;
   localparam logic [1:0] ZeroRunMax = 2'd3;
   localparam logic [1:0] ZeroRunCode = 2'd2;

   typedef logic [7:0] byte_type;
   typedef logic [HOLD_DEPTH-1:0][7:0] held_array_type;
   typedef logic [MAX_OUT-1:0][7:0] out_data_type;

   // result of one parser step: results to push and the next parser state
   typedef struct packed {
      logic [EMIT_W-1:0]   emit;
      out_data_type        data;
      logic [MAX_OUT-1:0]  last;
      held_array_type      held;
      logic [COUNT_W-1:0]  count;
      logic                synced;
      logic [1:0]          zero_run;
   } step_type;

endpackage

// File: hdl/anbs_step.sv
// anbs_step: combinational parser step, one stream byte against the held window
// depends on anbs_pkg
module anbs_step import anbs_pkg::*; (
   input  byte_type              stream_byte,
   input  held_array_type        held,
   input  logic [COUNT_W-1:0]    count,
   input  logic                  synced,
   input  logic [1:0]            zero_run,
   output step_type              nxt
);

   logic [HOLD_DEPTH:0][7:0] q;
   logic                     is_code;
   logic [1:0]               zr_inc;
   logic [1:0]               zr_new;
   logic [COUNT_W-1:0]       rem;
   logic [COUNT_W-1:0]       total;
   logic [COUNT_W-1:0]       keep;
   logic [COUNT_W-1:0]       avail;
   logic [EMIT_W-1:0]        emit;

   // held window with the new byte appended at position count
   always_comb begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         q[i] = (count == COUNT_W'(i)) ? stream_byte : held[i];
      end
      q[HOLD_DEPTH] = stream_byte;
   end

   assign is_code = (stream_byte == OneByte) && (zero_run >= ZeroRunCode);
   assign zr_inc  = (zero_run == ZeroRunMax) ? ZeroRunMax : zero_run + 2'd1;
   assign zr_new  = (stream_byte == ZeroByte) ? zr_inc : 2'd0;
   assign rem     = (count > {{(COUNT_W-2){1'b0}}, zero_run})
                    ? count - {{(COUNT_W-2){1'b0}}, zero_run} : '0;
   assign total   = count + COUNT_W'(1);
   // trailing zeros plus the byte before them may still turn out to be code or last
   assign keep    = ({{(COUNT_W-2){1'b0}}, zr_new} + COUNT_W'(1) > total)
                    ? total : {{(COUNT_W-2){1'b0}}, zr_new} + COUNT_W'(1);
   assign avail   = total - keep;

   always_comb begin
      nxt          = '0;
      nxt.held     = held;
      nxt.count    = count;
      nxt.synced   = synced;
      nxt.zero_run = zero_run;
      nxt.data[0]  = q[0];
      nxt.data[1]  = q[1];
      nxt.last     = '0;
      emit         = '0;
      if (!synced) begin
         nxt.count = '0;
         if (is_code) begin
            nxt.synced   = 1'b1;
            nxt.zero_run = 2'd0;
         end else begin
            nxt.zero_run = zr_new;
         end
      end else if (is_code) begin
         // strip the code zeros, the rest ends the unit
         emit         = (rem > COUNT_W'(MAX_OUT)) ? EMIT_W'(MAX_OUT) : rem[EMIT_W-1:0];
         nxt.emit     = emit;
         nxt.data[0]  = held[0];
         nxt.data[1]  = held[1];
         nxt.last[0]  = (emit == EMIT_W'(1));
         nxt.last[1]  = 1'b1;
         nxt.count    = '0;
         nxt.zero_run = 2'd0;
      end else begin
         emit         = (avail > COUNT_W'(MAX_OUT)) ? EMIT_W'(MAX_OUT) : avail[EMIT_W-1:0];
         nxt.emit     = emit;
         nxt.zero_run = zr_new;
         nxt.count    = total - {{(COUNT_W-EMIT_W){1'b0}}, emit};
         unique case (emit)
            EMIT_W'(1): nxt.held = q[HOLD_DEPTH:1];
            EMIT_W'(2): nxt.held = {q[HOLD_DEPTH], q[HOLD_DEPTH:2]};
            default:    nxt.held = q[HOLD_DEPTH-1:0];
         endcase
      end
   end

endmodule

// File: hdl/anbs_out_fifo.sv
// anbs_out_fifo: small result queue, up to two pushes and one pop per cycle
// depends on anbs_pkg
module anbs_out_fifo import anbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [EMIT_W-1:0]     push_count,
   input  out_data_type          push_data,
   input  logic [MAX_OUT-1:0]    push_last,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output byte_type              out_data,
   output logic                  out_last
);

   byte_type                 data_mem_ff [FIFO_DEPTH];
   logic                     last_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff, count_in;
   logic                     pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = data_mem_ff[rd_ptr_ff];
   assign out_last  = last_mem_ff[rd_ptr_ff];
   // space for a full step of results
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_OUT));

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count >= EMIT_W'(1)) begin
         data_mem_ff[wr_ptr_ff] <= push_data[0];
         last_mem_ff[wr_ptr_ff] <= push_last[0];
      end
      if (push_count >= EMIT_W'(2)) begin
         data_mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push_data[1];
         last_mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push_last[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/annexb_nal_unit_splitter.sv
// annexb_nal_unit_splitter: top level, splits an annex b byte stream into nal units
// depends on anbs_pkg, anbs_step and anbs_out_fifo
//
//   channel   ports                                   per transaction
//   req       req_valid/req_ready, req_stream_byte,   one stream byte
//             req_packet_end
//   rsp       rsp_valid/rsp_ready, rsp_nal_byte,      one nal byte, last flag
//             rsp_nal_last
//
// one stream byte per cycle while the queue has room: a byte is first registered in the
// input register, then the parser step updates the held window and pushes up to two
// bytes into a four-entry result queue.
// the step waits while the queue has fewer than two free entries.
// reset (synchronous) clears sync, zero run, held count and the queue.
module annexb_nal_unit_splitter import anbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       req_packet_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_nal_byte,
   output logic       rsp_nal_last
);

   logic                  in_valid_ff;
   byte_type              in_byte_ff;
   held_array_type        held_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  synced_ff;
   logic [1:0]            zero_run_ff;
   logic                  room;
   logic                  advance;
   logic [EMIT_W-1:0]     push_count;
   step_type              nxt;

   // packet boundaries do not affect parsing; req_packet_end is not used
   assign advance    = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || advance;
   assign push_count = advance ? nxt.emit : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
      if (advance) begin
         held_ff <= nxt.held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         synced_ff   <= 1'b0;
         zero_run_ff <= 2'd0;
      end else if (advance) begin
         count_ff    <= nxt.count;
         synced_ff   <= nxt.synced;
         zero_run_ff <= nxt.zero_run;
      end
   end

   anbs_step u_step (
      .stream_byte (in_byte_ff),
      .held        (held_ff),
      .count       (count_ff),
      .synced      (synced_ff),
      .zero_run    (zero_run_ff),
      .nxt         (nxt)
   );

   anbs_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (nxt.data),
      .push_last  (nxt.last),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_nal_byte),
      .out_last   (rsp_nal_last)
   );

   // nothing is held back while hunting for the first start code
   a_hunt_empty: assert property (@(posedge clock) disable iff (reset)
      !synced_ff |-> count_ff == '0)
      else $error("held bytes while not synced");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(HOLD_DEPTH))
      else $error("held count beyond window");

   a_no_emit_hunting: assert property (@(posedge clock) disable iff (reset)
      !synced_ff |-> push_count == '0)
      else $error("result pushed before sync");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost while queue full");

endmodule
